[rtl/core/rsrg_pkg.sv]
`default_nettype none

package rsrg_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	localparam int KEY_W = 31;
	localparam int TAG_W = 32;
	localparam int RUN_W = 16;

	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// Stream payload widths, rounded up to whole bytes.
	localparam int S_TDATA_W = ((KEY_W + TAG_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((KEY_W + TAG_W + RUN_W + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

endpackage

`default_nettype wire

[rtl/core/replacement_selection_run_generator_core.sv]
`default_nettype none

// Replacement-selection run generator. Records (key, tag) arrive on the s_*
// stream, with s_tlast marking the last record of the input. The first
// SLOT_COUNT records only fill the slot store and produce no output beat.
// Every later record produces one beat on m_*: the smallest unfrozen key in
// the store (the lowest slot wins a tie), tagged with its run number; the new
// record then takes that slot and is frozen if its key is below the key just
// sent. When every slot is frozen the run number advances (saturating at its
// maximum) and all slots thaw. A record marked last is handled the same way
// and then the store is flushed: the unfrozen entries in key order, then the
// frozen ones as the next run, after which the block starts from scratch.
// m_tuser flags the first beat of a run, and m_tlast flags the last beat that
// one input record causes. The block handles one record at a time and
// s_tready is low while it works. A single key comparator walks the slots one
// per cycle: a record that only fills the store is stored without leaving the
// idle state; a record that replaces an entry goes through a scan, a decision
// and an emit, with another scan and decision first when a run has to advance;
// during a flush each output beat takes a scan, a decision and an emit, with
// another scan and decision for the run change, and the flush ends with a scan
// that finds the store empty. The emit waits while m_tready is low.
module replacement_selection_run_generator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata, from bit 0 up: record_key[30:0], record_tag[31:0], one zero bit
	input  wire logic [rsrg_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire logic                            s_tlast,   // final_record
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// m_tdata, from bit 0 up: out_key[30:0], out_tag[31:0], run_number[15:0],
	// one zero bit
	output logic [rsrg_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                 m_tuser,   // starts_run
	output logic                                 m_tlast,   // last_result
	output logic                                 m_tvalid,
	input  wire logic                            m_tready
);

	localparam int N     = rsrg_pkg::SLOT_COUNT;
	localparam int IDX_W = rsrg_pkg::IDX_W;
	localparam int CNT_W = rsrg_pkg::CNT_W;
	localparam int KEY_W = rsrg_pkg::KEY_W;
	localparam int TAG_W = rsrg_pkg::TAG_W;
	localparam int RUN_W = rsrg_pkg::RUN_W;
	localparam int M_PAD_W = rsrg_pkg::M_TDATA_W - KEY_W - TAG_W - RUN_W;

	// Slot store. Key and tag contents are only ever read from valid slots.
	logic [KEY_W-1:0]  slot_key_q [N];
	logic [TAG_W-1:0]  slot_tag_q [N];
	logic [N-1:0]      slot_valid_q;
	logic [N-1:0]      slot_frozen_q;

	logic [CNT_W-1:0]  fill_count_q;
	logic [RUN_W-1:0]  run_q;
	logic              run_started_q;

	rsrg_pkg::state_t  state_q;

	// The record being worked on.
	logic [KEY_W-1:0]  in_key_q;
	logic [TAG_W-1:0]  in_tag_q;
	logic              fin_q;
	logic              draining_q;   // set while the store is being flushed

	// Scan of the slots: one slot per cycle through the shared comparator.
	logic [IDX_W-1:0]  scan_idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [TAG_W-1:0]  best_tag_q;
	logic [CNT_W-1:0]  valid_cnt_q;  // valid slots seen by the scan

	logic [KEY_W-1:0]  in_key;
	logic [TAG_W-1:0]  in_tag;
	logic              s_beat;
	logic              m_beat;
	logic              store_full;
	logic [KEY_W-1:0]  cmp_key;
	logic              key_lt;
	logic              cand;
	logic              better;
	logic              scan_done;
	logic [rsrg_pkg::M_TDATA_W-1:0] M_TDATA_W_PAD;

	assign in_key = s_tdata[KEY_W-1:0];
	assign in_tag = s_tdata[KEY_W+TAG_W-1:KEY_W];

	assign s_tready = (state_q == rsrg_pkg::ST_IDLE);
	assign m_tvalid = (state_q == rsrg_pkg::ST_EMIT);
	assign s_beat   = s_tvalid & s_tready;
	assign m_beat   = m_tvalid & m_tready;

	assign store_full = (fill_count_q == CNT_W'(N));

	// The comparator: it checks the scanned slot against the best key so far,
	// and while a beat is waiting it checks the new record against the key
	// being sent. An unfrozen valid slot wins only with a strictly smaller
	// key, so the lowest slot keeps a tie.
	assign cmp_key   = (state_q == rsrg_pkg::ST_EMIT) ? in_key_q : slot_key_q[scan_idx_q];
	assign key_lt    = (cmp_key < best_key_q);
	assign cand      = slot_valid_q[scan_idx_q] & ~slot_frozen_q[scan_idx_q];
	assign better    = cand & (~found_q | key_lt);
	assign scan_done = (scan_idx_q == IDX_W'(N - 1));

	always_comb begin
		M_TDATA_W_PAD = {{M_PAD_W{1'b0}}, run_q, best_tag_q, best_key_q};
	end
	assign m_tdata = M_TDATA_W_PAD;

	assign m_tuser = ~run_started_q;
	// While flushing, the beat is the last one exactly when it takes the
	// only valid slot left; a replacement beat is last unless a flush follows.
	assign m_tlast = draining_q ? (valid_cnt_q == CNT_W'(1)) : ~fin_q;

	// Payload of the slots: no reset needed.
	always_ff @(posedge clk) begin
		if (s_beat && !store_full) begin
			slot_key_q[fill_count_q[IDX_W-1:0]] <= in_key;
			slot_tag_q[fill_count_q[IDX_W-1:0]] <= in_tag;
		end else if (m_beat && !draining_q) begin
			slot_key_q[best_idx_q] <= in_key_q;
			slot_tag_q[best_idx_q] <= in_tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rsrg_pkg::ST_IDLE;
			slot_valid_q  <= '0;
			slot_frozen_q <= '0;
			fill_count_q  <= '0;
			run_q         <= '0;
			run_started_q <= 1'b0;
			fin_q         <= 1'b0;
			draining_q    <= 1'b0;
			scan_idx_q    <= '0;
			found_q       <= 1'b0;
			best_idx_q    <= '0;
			valid_cnt_q   <= '0;
			in_key_q      <= '0;
			in_tag_q      <= '0;
			best_key_q    <= '0;
			best_tag_q    <= '0;
		end else begin
			unique case (state_q)
				rsrg_pkg::ST_IDLE: begin
					if (s_beat) begin
						in_key_q    <= in_key;
						in_tag_q    <= in_tag;
						fin_q       <= s_tlast;
						scan_idx_q  <= '0;
						found_q     <= 1'b0;
						valid_cnt_q <= '0;
						if (!store_full) begin
							// Filling: store the record unfrozen, no output.
							slot_valid_q[fill_count_q[IDX_W-1:0]]  <= 1'b1;
							slot_frozen_q[fill_count_q[IDX_W-1:0]] <= 1'b0;
							fill_count_q <= fill_count_q + CNT_W'(1);
							draining_q   <= s_tlast;
							if (s_tlast) begin
								state_q <= rsrg_pkg::ST_SCAN;
							end
						end else begin
							draining_q <= 1'b0;
							state_q    <= rsrg_pkg::ST_SCAN;
						end
					end
				end

				rsrg_pkg::ST_SCAN: begin
					if (better) begin
						found_q    <= 1'b1;
						best_idx_q <= scan_idx_q;
						best_key_q <= slot_key_q[scan_idx_q];
						best_tag_q <= slot_tag_q[scan_idx_q];
					end
					if (slot_valid_q[scan_idx_q]) begin
						valid_cnt_q <= valid_cnt_q + CNT_W'(1);
					end
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_done) begin
						state_q <= rsrg_pkg::ST_DECIDE;
					end
				end

				rsrg_pkg::ST_DECIDE: begin
					scan_idx_q <= '0;
					if (found_q) begin
						// Keep the scan results for the output beat.
						state_q <= rsrg_pkg::ST_EMIT;
					end else if (!draining_q || valid_cnt_q != '0) begin
						// Everything left is frozen: start a new run and rescan.
						if (run_q != rsrg_pkg::RUN_MAX) begin
							run_q <= run_q + RUN_W'(1);
						end
						valid_cnt_q   <= '0;
						run_started_q <= 1'b0;
						slot_frozen_q <= '0;
						state_q       <= rsrg_pkg::ST_SCAN;
					end else begin
						// Flush complete: the next record opens a new stream.
						slot_valid_q  <= '0;
						slot_frozen_q <= '0;
						fill_count_q  <= '0;
						run_q         <= '0;
						run_started_q <= 1'b0;
						draining_q    <= 1'b0;
						fin_q         <= 1'b0;
						state_q       <= rsrg_pkg::ST_IDLE;
					end
				end

				rsrg_pkg::ST_EMIT: begin
					if (m_beat) begin
						run_started_q <= 1'b1;
						scan_idx_q    <= '0;
						found_q       <= 1'b0;
						valid_cnt_q   <= '0;
						if (draining_q) begin
							slot_valid_q[best_idx_q] <= 1'b0;
							state_q <= rsrg_pkg::ST_SCAN;
						end else begin
							// The new record takes the slot just sent.
							slot_valid_q[best_idx_q]  <= 1'b1;
							slot_frozen_q[best_idx_q] <= key_lt;
							if (fin_q) begin
								draining_q <= 1'b1;
								state_q    <= rsrg_pkg::ST_SCAN;
							end else begin
								state_q <= rsrg_pkg::ST_IDLE;
							end
						end
					end
				end

				default: begin
					state_q <= rsrg_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/rsrg_checker.sv]
`default_nettype none

// Watches both streams of the run generator, keeps its own copy of the slot
// store, and compares every output beat with the oldest predicted one.
module rsrg_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [rsrg_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic                             s_tlast,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	input  wire logic [rsrg_pkg::M_TDATA_W-1:0]   m_tdata,
	input  wire logic                             m_tuser,
	input  wire logic                             m_tlast,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	output int unsigned                           mismatch_count,
	output int unsigned                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = rsrg_pkg::SLOT_COUNT;
	localparam int KEY_W      = rsrg_pkg::KEY_W;
	localparam int TAG_W      = rsrg_pkg::TAG_W;
	localparam int RUN_W      = rsrg_pkg::RUN_W;
	localparam logic [RUN_W-1:0] RUN_MAX = rsrg_pkg::RUN_MAX;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [RUN_W-1:0] run;
		logic             starts;
		logic             last;
	} run_beat_t;

	logic [KEY_W-1:0] slot_key    [SLOT_COUNT];
	logic [TAG_W-1:0] slot_tag    [SLOT_COUNT];
	bit               slot_frozen [SLOT_COUNT];
	bit               slot_used   [SLOT_COUNT];
	int unsigned      filled;
	logic [RUN_W-1:0] run_idx;
	bit               run_open;

	// Beats caused by the record being predicted, and the queue of beats the
	// block still owes.
	run_beat_t item_beats [SLOT_COUNT+1];
	int        item_beat_n;
	run_beat_t owed_beats [$];

	task automatic report_mismatch(input string field, input logic [63:0] seen,
			input logic [63:0] wanted);
		if (mismatch_count < 50)
			$display("%0t rsrg_checker: %s got %0h want %0h", $time, field, seen, wanted);
		mismatch_count++;
	endtask

	function automatic void clear_store();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_frozen[i] = 1'b0;
			slot_used[i]   = 1'b0;
		end
		filled   = 0;
		run_idx  = '0;
		run_open = 1'b0;
	endfunction

	function automatic int lowest_open_slot();
		int best;
		best = -1;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (slot_used[i] && !slot_frozen[i] && (best < 0 || slot_key[i] < slot_key[best]))
				best = i;
		return best;
	endfunction

	function automatic void open_next_run();
		if (run_idx != RUN_MAX)
			run_idx++;
		run_open = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++)
			slot_frozen[i] = 1'b0;
	endfunction

	function automatic void send_slot(input int s);
		item_beats[item_beat_n] = '{key: slot_key[s], tag: slot_tag[s], run: run_idx,
			starts: !run_open, last: 1'b0};
		item_beat_n++;
		run_open = 1'b1;
	endfunction

	function automatic void flush_open_slots();
		int s;
		s = lowest_open_slot();
		while (s >= 0) begin
			send_slot(s);
			slot_used[s] = 1'b0;
			s = lowest_open_slot();
		end
	endfunction

	function automatic void sort_record(input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic fin);
		int               s;
		logic [KEY_W-1:0] prev;
		bit               left;
		item_beat_n = 0;
		if (filled < SLOT_COUNT) begin
			slot_key[filled]    = key;
			slot_tag[filled]    = tag;
			slot_frozen[filled] = 1'b0;
			slot_used[filled]   = 1'b1;
			filled++;
		end else begin
			s = lowest_open_slot();
			if (s < 0) begin
				open_next_run();
				s = lowest_open_slot();
			end
			if (s >= 0) begin
				prev = slot_key[s];
				send_slot(s);
				slot_key[s]    = key;
				slot_tag[s]    = tag;
				slot_used[s]   = 1'b1;
				slot_frozen[s] = key < prev;
			end
		end
		if (fin) begin
			flush_open_slots();
			left = 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++)
				if (slot_used[i])
					left = 1'b1;
			if (left) begin
				open_next_run();
				flush_open_slots();
			end
			clear_store();
		end
		if (item_beat_n > 0)
			item_beats[item_beat_n-1].last = 1'b1;
		for (int i = 0; i < item_beat_n; i++)
			owed_beats.push_back(item_beats[i]);
	endfunction

	always @(posedge clk) begin
		run_beat_t got;
		run_beat_t want;
		if (!arst_n) begin
			clear_store();
			owed_beats.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			// Results first: a beat can never belong to a record taken at the same edge.
			if (m_tvalid && m_tready) begin
				got = '{key: m_tdata[KEY_W-1:0], tag: m_tdata[KEY_W +: TAG_W],
					run: m_tdata[KEY_W+TAG_W +: RUN_W], starts: m_tuser, last: m_tlast};
				if (owed_beats.size() == 0) begin
					report_mismatch("beat with nothing owed, out_key", 64'(got.key), 64'd0);
				end else begin
					want = owed_beats.pop_front();
					if (got.key !== want.key)
						report_mismatch("out_key", 64'(got.key), 64'(want.key));
					if (got.tag !== want.tag)
						report_mismatch("out_tag", 64'(got.tag), 64'(want.tag));
					if (got.run !== want.run)
						report_mismatch("run_number", 64'(got.run), 64'(want.run));
					if (got.starts !== want.starts)
						report_mismatch("starts_run", 64'(got.starts), 64'(want.starts));
					if (got.last !== want.last)
						report_mismatch("last_result", 64'(got.last), 64'(want.last));
				end
			end
			if (s_tvalid && s_tready)
				sort_record(s_tdata[KEY_W-1:0], s_tdata[KEY_W +: TAG_W], s_tlast);
			outstanding <= owed_beats.size();
		end
	end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

// Stimulus and verdict for the replacement-selection run generator. The
// checker beside the block does all prediction and comparison; this module
// only feeds records, throttles the output side, and decides pass or fail.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = rsrg_pkg::SLOT_COUNT;
	localparam int KEY_W      = rsrg_pkg::KEY_W;
	localparam int TAG_W      = rsrg_pkg::TAG_W;
	localparam int S_TDATA_W  = rsrg_pkg::S_TDATA_W;
	localparam int M_TDATA_W  = rsrg_pkg::M_TDATA_W;

	localparam logic [KEY_W-1:0] KEY_TOP     = '1;
	localparam int               ITEM_TARGET = 370;
	localparam int               CYCLE_LIMIT = 2000000;

	// How the keys of one random stream are shaped.
	typedef enum int {
		KEYS_WIDE,     // uniform over the whole key range
		KEYS_TIED,     // a handful of values, so ties are common
		KEYS_FALLING,  // mostly descending, so records freeze and runs advance
		KEYS_RISING,   // mostly ascending, so runs grow long
		KEYS_EDGE      // only the extreme keys
	} key_shape_e;

	// How the output side accepts beats during one span of cycles.
	typedef enum int {
		READY_ALWAYS,
		READY_HALF,
		READY_SPARSE,
		READY_HELD
	} ready_shape_e;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [S_TDATA_W-1:0]  s_tdata;   // record_key[30:0], record_tag[31:0], zero
	logic                  s_tlast;   // final_record
	logic                  s_tvalid;
	logic                  s_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // out_key[30:0], out_tag[31:0], run_number[15:0], zero
	logic                  m_tuser;   // starts_run
	logic                  m_tlast;   // last_result
	logic                  m_tvalid;
	logic                  m_tready;

	int unsigned           mismatch_count;
	int unsigned           outstanding;
	int                    items_sent = 0;
	int                    burst_left = 0;
	int unsigned           cycle_count = 0;

	replacement_selection_run_generator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	rsrg_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #6ns clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The output side follows a pattern of spans. Each span picks a shape:
	// always ready, ready half the time, ready rarely, or held low throughout.
	// The held spans are what make the block sit on a finished beat for a while.
	always @(posedge clk) begin
		int           span_left;
		int           pick;
		ready_shape_e shape;
		if (span_left <= 0) begin
			span_left = $urandom_range(1, 40);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				shape = READY_ALWAYS;
			else if (pick < 7)
				shape = READY_HALF;
			else if (pick < 9)
				shape = READY_SPARSE;
			else
				shape = READY_HELD;
		end
		span_left--;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case (shape)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
				READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:      m_tready <= 1'b0;
			endcase
		end
	end

	// Offers one record and returns at the edge where it was taken. The sender
	// works in bursts: when a burst is used up it may go quiet for a random gap
	// before the next one. A gap of zero keeps s_tvalid high across the burst
	// boundary, which gives long stretches without idling.
	task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tdata  <= {1'b0, tag, key};
		s_tlast  <= fin;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Stops offering records until the block has delivered everything owed.
	// The count from the checker is registered, so the first edge is always
	// waited out before looking at it.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [KEY_W-1:0] draw_key(input key_shape_e shape,
			input logic [KEY_W-1:0] prev);
		logic [KEY_W-1:0] step;
		step = KEY_W'($urandom_range(0, 4096));
		// Falling and rising streams now and then jump, so they do not pin at an end.
		if ((shape == KEYS_FALLING || shape == KEYS_RISING) && $urandom_range(0, 7) == 0)
			return KEY_W'($urandom());
		case (shape)
			KEYS_TIED:    return KEY_W'($urandom_range(0, 5));
			KEYS_FALLING: return (prev > step) ? prev - step : KEY_W'($urandom());
			KEYS_RISING:  return (prev < KEY_TOP - step) ? prev + step : KEY_W'($urandom());
			KEYS_EDGE: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return KEY_W'(1);
					2:       return KEY_TOP - 1;
					default: return KEY_TOP;
				endcase
			end
			default:      return KEY_W'($urandom());
		endcase
	endfunction

	initial begin
		int               len;
		key_shape_e       shape;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;

		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n   <= 1'b1;

		// A lone final record: the shortest possible fill, flushed at once,
		// with the largest key and an all-ones tag.
		send_record(KEY_TOP, '1, 1'b1);

		// A short fill with a tie and a zero key: the tie must go to the lower slot.
		send_record(KEY_W'(5), '0, 1'b0);
		send_record(KEY_W'(5), '1, 1'b0);
		send_record('0, TAG_W'(32'h0000_1234), 1'b1);

		// Pause until the block has delivered everything before going on.
		hold_until_drained();

		// Fill the store, with the largest key, a tie and a spread of values.
		send_record(KEY_TOP, TAG_W'(32'hA000_0000), 1'b0);
		send_record(KEY_W'(100), TAG_W'(32'hA000_0001), 1'b0);
		send_record(KEY_W'(100), TAG_W'(32'hA000_0002), 1'b0);
		send_record(KEY_W'(50), TAG_W'(32'hA000_0003), 1'b0);
		send_record(KEY_W'(10), TAG_W'(32'hA000_0004), 1'b0);
		send_record(KEY_W'(200), TAG_W'(32'hA000_0005), 1'b0);
		send_record(KEY_W'(300), TAG_W'(32'hA000_0006), 1'b0);
		send_record(KEY_W'(400), TAG_W'(32'hA000_0007), 1'b0);
		// Each newcomer is below the key it replaces, so all eight slots
		// freeze; the largest key is emitted last in this run.
		send_record(KEY_W'(9), '1, 1'b0);
		send_record(KEY_W'(8), TAG_W'(32'hB000_0001), 1'b0);
		send_record(KEY_W'(7), TAG_W'(32'hB000_0002), 1'b0);
		send_record(KEY_W'(6), TAG_W'(32'hB000_0003), 1'b0);
		send_record(KEY_W'(5), TAG_W'(32'hB000_0004), 1'b0);
		send_record(KEY_W'(4), TAG_W'(32'hB000_0005), 1'b0);
		send_record(KEY_W'(3), TAG_W'(32'hB000_0006), 1'b0);
		send_record(KEY_W'(2), '0, 1'b0);
		// With every slot frozen the run advances before the emit. This final
		// record then freezes too, so the flush crosses into one more run and
		// the record causes the most beats one record can.
		send_record('0, TAG_W'(32'h5555_AAAA), 1'b1);

		// Random streams, each closed by a final record. Most are long enough
		// to get past the fill; some end during it.
		while (items_sent < ITEM_TARGET) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, SLOT_COUNT)
				: $urandom_range(SLOT_COUNT + 1, 40);
			shape = key_shape_e'($urandom_range(0, 4));
			key = KEY_W'($urandom());
			for (int i = 0; i < len; i++) begin
				key = draw_key(shape, key);
				if (shape == KEYS_EDGE && $urandom_range(0, 1) == 1)
					tag = ($urandom_range(0, 1) == 1) ? '1 : '0;
				else
					tag = TAG_W'($urandom());
				send_record(key, tag, i == len - 1);
			end
			if ($urandom_range(0, 5) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		// Keep watching for any beat the block should not be sending.
		repeat (40) @(posedge clk);

		if (mismatch_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
